FILE: rtl/interval_column_best_fit_defines.svh
// Assertion macros used by the RTL file that checks its own logic.
`ifndef INTERVAL_COLUMN_BEST_FIT_DEFINES_SVH
`define INTERVAL_COLUMN_BEST_FIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ICBF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icbf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ICBF_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icbf: next-cycle check failed");

`endif

FILE: rtl/icbf_pkg.sv
package icbf_pkg;

    localparam int TIME_W              = 17;
    localparam int DEFAULT_MAX_COLUMNS = 16;
    localparam logic [TIME_W-1:0] DAY_SECONDS = TIME_W'(60 * 60 * 24);

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic              first_of_day;
        logic [2:0]        day_index;
    } t_in;

    typedef struct packed {
        logic [3:0] column;
        logic [4:0] column_count;
        logic [2:0] split_day;
        logic       overflow;
    } t_out;

    // Microprogram addresses.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_UPDATE
    } t_step;

    // Jump conditions; a step whose condition is false repeats.
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_SCAN_DONE
    } t_cond;

    typedef struct packed {
        logic  in_ready;
        logic  setup;
        logic  scan;
        logic  update;
        t_cond cond;
        t_step target;
    } t_ctrl;

    // Status returned by the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic scan_done;
    } t_flags;

    // Control store.
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '{in_ready: 1'b0, setup: 1'b0, scan: 1'b0, update: 1'b0,
              cond: COND_ALWAYS, target: ST_IDLE};
        case (step)
            ST_IDLE: begin
                w.in_ready = 1'b1;
                w.cond     = COND_IN_VALID;
                w.target   = ST_SETUP;
            end
            ST_SETUP: begin
                w.setup  = 1'b1;
                w.target = ST_SCAN;
            end
            ST_SCAN: begin
                w.scan   = 1'b1;
                w.cond   = COND_SCAN_DONE;
                w.target = ST_UPDATE;
            end
            ST_UPDATE: begin
                w.update = 1'b1;
                w.target = ST_IDLE;
            end
            default: begin
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/icbf_seq.sv
module icbf_seq
    import icbf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    t_step r_pc;
    t_step n_pc;
    logic  w_cond;

    always_comb begin
        o_ctrl = ucode(r_pc);
    end

    always_comb begin
        case (o_ctrl.cond)
            COND_ALWAYS:    w_cond = 1'b1;
            COND_IN_VALID:  w_cond = i_flags.in_valid;
            COND_SCAN_DONE: w_cond = i_flags.scan_done;
            default:        w_cond = 1'b1;
        endcase
        n_pc = w_cond ? o_ctrl.target : r_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

FILE: rtl/interval_column_best_fit.sv
// One interval is in flight at a time: a new input beat is taken only once the previous
// one has been written back, and a result beat that waits to be taken holds back the
// write-back of the next. The one comparator walks the open columns through the single
// read port of the last-end memory; an exact fit ends the walk early.
// Synchronous active-low reset empties the columns and result register, not the memory.
`include "interval_column_best_fit_defines.svh"

module interval_column_best_fit
    import icbf_pkg::*;
#(
    parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    // CW holds a column count (0..MAX_COLUMNS), IW indexes one column.
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_COLUMNS);

    // The sequencer steps through a four-word microprogram: wait for a beat,
    // set up the scan, scan the open columns until done and the result
    // register is free, then write back and present the result.
    t_ctrl  ctl;
    t_flags flags;

    icbf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctl)
    );

    assign o_in_ready = ctl.in_ready;

    // Captured input beat.
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_end;
    logic              r_clear;
    logic [2:0]        r_day;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_start <= i_in.start_time;
            r_end   <= i_in.end_time;
            r_clear <= i_in.first_of_day;
            r_day   <= i_in.day_index;
        end
    end

    // Last end time of each column. Only open columns are ever read, and
    // each column is written when it opens, so the contents need no reset.
    logic [TIME_W-1:0] r_mem [MAX_COLUMNS];
    logic [TIME_W-1:0] r_rd_data;

    // Scan state. Each read is issued in the cycle before its compare, so
    // r_cmp_vld and r_cmp_idx follow the data coming out of the memory.
    logic [CW-1:0]     r_used;
    logic [CW-1:0]     r_idx;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;
    logic              r_hit;
    logic              r_found;
    logic [IW-1:0]     r_best;
    logic [TIME_W-1:0] r_best_gap;

    // Result register.
    logic r_out_valid;
    t_out r_out;

    logic              w_issue;
    logic              w_hit_now;
    logic              w_better;
    logic [TIME_W-1:0] w_gap;

    always_comb begin
        w_gap     = r_start - r_rd_data;
        // An exact fit ends the walk; otherwise keep the smallest positive gap.
        // The strict compare keeps the lowest index on a tie, and the starting
        // value of the best gap rules out gaps of a whole day or more.
        w_hit_now = r_cmp_vld && !r_hit && (r_start == r_rd_data);
        w_better  = r_cmp_vld && !r_hit && (r_start > r_rd_data) && (w_gap < r_best_gap);
        w_issue   = ctl.scan && !r_hit && !w_hit_now && (r_idx < r_used);
        flags.in_valid  = i_in_valid;
        flags.scan_done = !r_cmp_vld && (r_hit || (r_idx == r_used))
                          && (!r_out_valid || i_out_ready);
    end

    // Write-back: a fitting column takes the end time, otherwise a new
    // column opens at r_used if there is room, otherwise overflow.
    logic          w_room;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_idx;
    logic [CW-1:0] n_used;
    logic [CW-1:0] w_col;
    logic [31:0]   w_col32;
    logic [31:0]   w_cnt32;

    always_comb begin
        w_room   = r_used < MAX_CNT;
        w_wr_en  = ctl.update && (r_found || w_room);
        w_wr_idx = r_found ? r_best : r_used[IW-1:0];
        n_used   = (!r_found && w_room) ? r_used + CW'(1) : r_used;
        if (r_found) begin
            w_col = CW'(r_best);
        end else if (w_room) begin
            w_col = r_used;
        end else begin
            w_col = '0;
        end
        w_col32 = 32'(w_col);
        w_cnt32 = 32'(n_used);
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_data <= r_mem[r_idx[IW-1:0]];
        end
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= r_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            if (ctl.setup) begin
                // A first-of-day beat empties every column before placement.
                if (r_clear) begin
                    r_used <= '0;
                end
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
                r_found   <= 1'b0;
            end else if (ctl.update) begin
                r_used <= n_used;
            end else if (ctl.scan) begin
                r_cmp_vld <= w_issue;
                if (w_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (w_hit_now) begin
                    r_hit   <= 1'b1;
                    r_found <= 1'b1;
                end else if (w_better) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.setup) begin
            r_best_gap <= DAY_SECONDS;
        end else if (ctl.scan && w_better) begin
            r_best_gap <= w_gap;
        end
        if (ctl.scan && w_issue) begin
            r_cmp_idx <= r_idx[IW-1:0];
        end
        if (ctl.scan && (w_hit_now || w_better)) begin
            r_best <= r_cmp_idx;
        end
    end

    // Result register: loaded by the update step, which the sequencer enters
    // only when the register is empty or being drained in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.update) begin
            r_out.column       <= w_col32[3:0];
            r_out.column_count <= w_cnt32[4:0];
            r_out.split_day    <= r_day;
            r_out.overflow     <= !r_found && !w_room;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Only one interval is in flight at a time.
    `ICBF_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // The open-column count never passes the number of columns.
    `ICBF_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= MAX_CNT)
    // A result is never written over one that has not been taken.
    `ICBF_ASSERT_IMP(a_load_free, i_clk, i_rst_n, ctl.update, !r_out_valid || i_out_ready)
    // An exact fit always marks a winning column.
    `ICBF_ASSERT_IMP(a_hit_found, i_clk, i_rst_n, r_hit, r_found)

endmodule

FILE: tb/interval_column_best_fit_test.sv
module interval_column_best_fit_test;
    import icbf_pkg::*;

    // A directed row carries one input beat and, where the answer is obvious,
    // the result beat typed in by hand. Rows with typed == 0 are checked
    // against the column placement model below.
    typedef struct packed {
        t_in  stim;
        logic typed;
        t_out want;
    } t_dir_row;

    localparam int DIR_ROWS       = 26;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int HOLD_OFF       = 400;
    localparam int HOLD_AT_RESULT = 600;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    // Directed part. The first sixteen intervals all start at midnight and run
    // to the last second, so none fits behind another and every one opens a
    // new column; the seventeenth then finds all columns in use and overflows.
    // After that come the largest 17-bit times with a fresh day, an exact fit
    // that also ends before it starts, a gap of a whole day that must not fit,
    // best-fit choices, and a tie between two columns with equal last ends.
    t_dir_row directed_tab [DIR_ROWS] = '{
        '{'{17'd0,      17'd86399,  1'b1, 3'd0}, 1'b1, '{4'd0,  5'd1,  3'd0, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd1}, 1'b1, '{4'd1,  5'd2,  3'd1, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd2}, 1'b1, '{4'd2,  5'd3,  3'd2, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd3}, 1'b1, '{4'd3,  5'd4,  3'd3, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd4}, 1'b1, '{4'd4,  5'd5,  3'd4, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd5}, 1'b1, '{4'd5,  5'd6,  3'd5, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd6}, 1'b1, '{4'd6,  5'd7,  3'd6, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd0}, 1'b1, '{4'd7,  5'd8,  3'd0, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd1}, 1'b1, '{4'd8,  5'd9,  3'd1, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd2}, 1'b1, '{4'd9,  5'd10, 3'd2, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd3}, 1'b1, '{4'd10, 5'd11, 3'd3, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd4}, 1'b1, '{4'd11, 5'd12, 3'd4, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd5}, 1'b1, '{4'd12, 5'd13, 3'd5, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd6}, 1'b1, '{4'd13, 5'd14, 3'd6, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd0}, 1'b1, '{4'd14, 5'd15, 3'd0, 1'b0}},
        '{'{17'd0,      17'd86399,  1'b0, 3'd1}, 1'b1, '{4'd15, 5'd16, 3'd1, 1'b0}},
        '{'{17'd0,      17'd5,      1'b0, 3'd6}, 1'b1, '{4'd0,  5'd16, 3'd6, 1'b1}},
        '{'{17'd131071, 17'd131071, 1'b1, 3'd7}, 1'b1, '{4'd0,  5'd1,  3'd7, 1'b0}},
        '{'{17'd131071, 17'd0,      1'b0, 3'd3}, 1'b1, '{4'd0,  5'd1,  3'd3, 1'b0}},
        '{'{17'd86400,  17'd100,    1'b0, 3'd2}, 1'b0, '0},
        '{'{17'd100,    17'd50,     1'b0, 3'd2}, 1'b0, '0},
        '{'{17'd50,     17'd7,      1'b0, 3'd2}, 1'b0, '0},
        '{'{17'd10,     17'd10,     1'b1, 3'd4}, 1'b1, '{4'd0,  5'd1,  3'd4, 1'b0}},
        '{'{17'd5,      17'd10,     1'b0, 3'd4}, 1'b0, '0},
        '{'{17'd20,     17'd30,     1'b0, 3'd4}, 1'b0, '0},
        '{'{17'd86399,  17'd0,      1'b0, 3'd5}, 1'b0, '0}
    };

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in        = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    interval_column_best_fit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Model of the column state: the last end time of every open column and
    // the number of columns open. The memory itself is never read below, only
    // entries that were written since the last clear.
    logic [TIME_W-1:0] col_last_end [DEFAULT_MAX_COLUMNS];
    int                cols_open = 0;

    // Result beats still owed by the block, oldest first.
    t_out placements_due [$];
    // Every interval that the sender will offer, directed rows first.
    t_in  intervals_q [$];

    int intervals_in   = 0;
    int placements_out = 0;
    int n_bad          = 0;
    int n_exact        = 0;
    int n_best_fit     = 0;
    int n_opened       = 0;
    int n_overflow     = 0;
    int n_day_sets     = 0;
    int idle_cycles    = 0;

    // Places one interval the way the block must: an exact fit takes the first
    // such column at once, otherwise the smallest gap below a whole day wins
    // with the lowest index on a tie, otherwise a new column opens if any is
    // left, and if none is left the beat reports overflow and stores nothing.
    function automatic t_out place_interval(input t_in x);
        t_out r;
        int   best;
        int   best_gap;
        int   gap;
        int   c;
        bit   exact;
        if (x.first_of_day) begin
            cols_open = 0;
            n_day_sets++;
        end
        best     = cols_open;
        best_gap = int'(DAY_SECONDS);
        exact    = 1'b0;
        for (c = 0; c < cols_open; c++) begin
            gap = int'(x.start_time) - int'(col_last_end[c]);
            if (gap == 0) begin
                best  = c;
                exact = 1'b1;
                break;
            end
            if (gap > 0 && gap < best_gap) begin
                best_gap = gap;
                best     = c;
            end
        end
        r.overflow  = 1'b0;
        r.split_day = x.day_index;
        if (best < cols_open) begin
            col_last_end[best] = x.end_time;
            r.column = 4'(best);
            if (exact) begin
                n_exact++;
            end else begin
                n_best_fit++;
            end
        end else if (cols_open < DEFAULT_MAX_COLUMNS) begin
            col_last_end[cols_open] = x.end_time;
            r.column = 4'(cols_open);
            cols_open++;
            n_opened++;
        end else begin
            r.overflow = 1'b1;
            r.column   = '0;
            n_overflow++;
        end
        r.column_count = 5'(cols_open);
        return r;
    endfunction

    // Appends one day set of random intervals. Most sets start with a clear
    // and keep to one style of timing so that columns really fill up; about
    // one set in ten leaves the clear out and carries on the previous columns.
    task automatic add_day_set();
        int                style;
        int                len;
        int                k;
        int                cursor;
        int                dur;
        bit                broken;
        logic [2:0]        day;
        logic [TIME_W-1:0] s;
        logic [TIME_W-1:0] e;
        logic [TIME_W-1:0] ends [$];
        logic [TIME_W-1:0] corner [6] = '{17'd0, 17'd1, 17'd86398, 17'd86399,
                                         17'd86400, 17'd131071};
        t_in               x;
        style  = $urandom_range(0, 9);
        len    = (style == 6) ? $urandom_range(17, 40) : $urandom_range(1, 40);
        broken = ($urandom_range(0, 9) == 0);
        day    = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        cursor = $urandom_range(0, 3600);
        for (k = 0; k < len; k++) begin
            case (style)
                0, 1, 2, 3: begin
                    // A realistic day: starts move forward through the day.
                    dur    = $urandom_range(1, 7200);
                    s      = TIME_W'(cursor);
                    e      = TIME_W'((cursor + dur > 86399) ? 86399 : cursor + dur);
                    cursor = cursor + $urandom_range(0, 2400);
                    if (cursor > 86399) begin
                        cursor = 86399;
                    end
                end
                4, 5: begin
                    s = TIME_W'($urandom_range(0, 63));
                    e = TIME_W'($urandom_range(0, 63));
                end
                6: begin
                    // Everything starts near midnight, so columns pile up
                    // until the block runs out of them.
                    s = TIME_W'($urandom_range(0, 3));
                    e = TIME_W'($urandom_range(4, 86399));
                end
                7: begin
                    s = TIME_W'($urandom_range(0, 131071));
                    e = TIME_W'($urandom_range(0, 131071));
                end
                8: begin
                    s = corner[$urandom_range(0, 5)];
                    e = corner[$urandom_range(0, 5)];
                end
                default: begin
                    // Coarse times make equal gaps, and so ties, common.
                    s = TIME_W'(10 * $urandom_range(0, 20));
                    e = TIME_W'(10 * $urandom_range(0, 20));
                end
            endcase
            // Reuse an earlier end as this start to aim at exact fits.
            if (ends.size() > 0 && style != 6 && style != 7 && $urandom_range(0, 2) == 0) begin
                s = ends[$urandom_range(0, ends.size() - 1)];
            end
            ends = {ends, e};
            x.start_time   = s;
            x.end_time     = e;
            x.first_of_day = (k == 0) ? !broken : ($urandom_range(0, 63) == 0);
            x.day_index    = day;
            intervals_q = {intervals_q, x};
        end
    endtask

    // Offers one input beat and returns at the edge that accepts it. Valid is
    // left high so that a following beat can go out without a gap.
    task automatic send_interval(input t_in x);
        i_in       <= x;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every owed result beat has come back.
    // The first edge lets the monitor record the last accepted beat.
    task automatic drain_placements();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (placements_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Sender: directed rows, then the random day sets, in bursts of random
    // length with random gaps. It pauses twice until the block is empty.
    initial begin : sender
        int k;
        int burst_left;
        int mid;
        foreach (directed_tab[r]) begin
            intervals_q = {intervals_q, directed_tab[r].stim};
        end
        while (intervals_q.size() < DIR_ROWS + RANDOM_ITEMS) begin
            add_day_set();
        end
        mid        = DIR_ROWS + (intervals_q.size() - DIR_ROWS) / 2;
        burst_left = $urandom_range(1, 32);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (k = 0; k < intervals_q.size(); k++) begin
            if (k == DIR_ROWS || k == mid) begin
                drain_placements();
            end
            send_interval(intervals_q[k]);
            burst_left--;
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 32);
            end
        end
        drain_placements();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        while (placements_due.size() != 0) begin
            n_bad++;
            if (n_bad <= 10) begin
                $display("missing result beat: column %0d count %0d day %0d overflow %0d",
                         placements_due[0].column, placements_due[0].column_count,
                         placements_due[0].split_day, placements_due[0].overflow);
            end
            void'(placements_due.pop_front());
        end
        $display("%0d intervals in %0d day sets, %0d result beats checked",
                 intervals_in, n_day_sets, placements_out);
        $display("%0d exact fits, %0d best fits, %0d new columns, %0d overflows",
                 n_exact, n_best_fit, n_opened, n_overflow);
        if (n_bad == 0) begin
            $display("interval_column_best_fit: match");
        end else begin
            $display("interval_column_best_fit: mismatch");
        end
        $finish;
    end

    // Receiver: ready follows a pattern that is picked anew for each random span,
    // from always ready to mostly stalled. Once, after a few hundred results,
    // it holds off for a long stretch so the block fills and stalls its input.
    initial begin : receiver
        int mode;
        int span;
        int cyc;
        bit held_off;
        cyc      = 0;
        held_off = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 150);
            repeat (span) begin
                @(posedge i_clk);
                if (!held_off && placements_out >= HOLD_AT_RESULT) begin
                    held_off = 1'b1;
                    i_out_ready <= 1'b0;
                    repeat (HOLD_OFF) @(posedge i_clk);
                end
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= (cyc % 3 == 0);
                    default: i_out_ready <= ($urandom_range(0, 5) == 0);
                endcase
                cyc++;
            end
        end
    end

    // Monitor: every accepted input beat is run through the model and its
    // result queued; every accepted result beat is compared with the oldest
    // queued one. The watchdog ends the run if no beat moves for too long.
    always @(posedge i_clk) begin : monitor
        t_out want;
        t_out got;
        if (i_rst_n) begin
            idle_cycles++;
            if (i_in_valid && o_in_ready) begin
                want = place_interval(i_in);
                if (intervals_in < DIR_ROWS && directed_tab[intervals_in].typed) begin
                    want = directed_tab[intervals_in].want;
                end
                placements_due = {placements_due, want};
                intervals_in++;
                idle_cycles = 0;
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out;
                placements_out++;
                idle_cycles = 0;
                if (placements_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("result beat %0d with nothing owed: %h", placements_out, got);
                    end
                end else begin
                    want = placements_due.pop_front();
                    if (got.column !== want.column || got.column_count !== want.column_count ||
                        got.split_day !== want.split_day || got.overflow !== want.overflow) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("result beat %0d: column %0d/%0d count %0d/%0d %s",
                                     placements_out, want.column, got.column,
                                     want.column_count, got.column_count,
                                     "(expected/actual)");
                            $display("    day %0d/%0d overflow %0d/%0d",
                                     want.split_day, got.split_day,
                                     want.overflow, got.overflow);
                        end
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", idle_cycles);
                $display("interval_column_best_fit: mismatch");
                $finish;
            end
        end
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/icbf_pkg.sv
rtl/icbf_seq.sv
rtl/interval_column_best_fit.sv
tb/interval_column_best_fit_test.sv
